/* design/pac_pkg.sv */
// Shared constants, register indexes and lane control type for the pot angle conditioner.
package pac_pkg;

    localparam int SAMPLE_BITS       = 12;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CHANNELS          = 3;
    localparam int ALPHA_BITS        = 16;
    localparam int LIMIT_BITS        = 15;
    localparam int ANGLE_BITS        = 16;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 16;

    localparam int HALF_SHIFT = SAMPLE_BITS - 1;
    localparam logic [SAMPLE_BITS-1:0] HALF_SCALE =
        SAMPLE_BITS'((2 ** SAMPLE_BITS - 1) / 2);

    localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] DEAD_RST   = SAMPLE_BITS'(20);
    localparam logic [ALPHA_BITS-1:0]  ALPHA_RST  = ALPHA_BITS'(3277);
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RST  = LIMIT_BITS'(24576);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_PITCH = 3'd0,
        REG_CENTER_ROLL  = 3'd1,
        REG_CENTER_YAW   = 3'd2,
        REG_DEAD_BAND    = 3'd3,
        REG_ALPHA        = 3'd4,
        REG_ANGLE_LIMIT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic mult;
        logic level;
        logic offset;
        logic scale;
        logic divide;
        logic first;
    } t_lane_ctl;

endpackage

/* design/pac_lane.sv */
// One channel: moving average, center offset, deadzone and scaling to an angle.
module pac_lane #(
    parameter int FRACTION_BITS = pac_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pac_pkg::t_lane_ctl                     i_ctl,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0] i_center,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0] i_dead_band,
    input  logic        [pac_pkg::ALPHA_BITS-1:0]  i_alpha,
    input  logic        [pac_pkg::LIMIT_BITS-1:0]  i_limit,
    output logic signed [pac_pkg::ANGLE_BITS-1:0]  o_angle
);

    localparam int SB = pac_pkg::SAMPLE_BITS;
    localparam int LW = SB + FRACTION_BITS;
    localparam int DW = LW + 1;
    localparam int MW = DW + pac_pkg::ALPHA_BITS + 1;
    localparam int PW = SB + pac_pkg::LIMIT_BITS;
    localparam int K  = pac_pkg::HALF_SHIFT;

    logic        [SB-1:0] r_smp;
    logic        [LW-1:0] r_lvl, n_lvl;
    logic signed [MW-1:0] r_prod;
    logic        [SB-1:0] r_mag;
    logic                 r_neg, r_zero, r_sat;
    logic        [PW-1:0] r_p;
    logic        [PW-1:0] r_q;

    logic signed [DW-1:0]                    w_diff;
    logic signed [pac_pkg::ALPHA_BITS:0]     w_alpha;
    logic signed [MW-1:0]                    w_prod;
    logic signed [MW-1:0]                    w_step;
    logic        [MW-1:0]                    w_sum;
    logic        [SB-1:0]                    w_whole;
    logic                                    w_neg;
    logic        [SB-1:0]                    w_mag;
    logic        [PW:0]                      w_qsum;
    logic        [PW-1:0]                    w_rem;
    logic        [PW-1:0]                    w_q;
    logic        [pac_pkg::ANGLE_BITS-1:0]   w_abs;

    assign w_diff  = $signed({1'b0, r_smp, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, r_lvl});
    assign w_alpha = $signed({1'b0, i_alpha});
    assign w_prod  = w_diff * w_alpha;

    assign w_step = r_prod >>> pac_pkg::ALPHA_BITS;
    assign w_sum  = w_step + {{(MW - LW){1'b0}}, r_lvl};
    assign n_lvl  = i_ctl.first ? {r_smp, {FRACTION_BITS{1'b0}}} : w_sum[LW-1:0];

    assign w_whole = r_lvl[LW-1:FRACTION_BITS];
    assign w_neg   = w_whole < i_center;
    assign w_mag   = w_neg ? (i_center - w_whole) : (w_whole - i_center);

    assign w_qsum = ({1'b0, r_p} + {{(K + 1){1'b0}}, r_p[PW-1:K]}) >> K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else if (i_ctl.level) begin
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_smp <= i_sample;
        end
        if (i_ctl.mult) begin
            r_prod <= w_prod;
        end
        if (i_ctl.offset) begin
            r_mag  <= w_mag;
            r_neg  <= w_neg;
            r_zero <= w_mag < i_dead_band;
            r_sat  <= w_mag >= pac_pkg::HALF_SCALE;
        end
        if (i_ctl.scale) begin
            r_p <= PW'(r_mag) * PW'(i_limit);
        end
        if (i_ctl.divide) begin
            r_q <= w_qsum[PW-1:0];
        end
    end

    always_comb begin
        w_rem = r_p - (r_q << K) + r_q;
        w_q   = (w_rem >= PW'(pac_pkg::HALF_SCALE)) ? r_q + PW'(1) : r_q;
        if (r_zero) begin
            w_abs = '0;
        end else if (r_sat) begin
            w_abs = pac_pkg::ANGLE_BITS'(i_limit);
        end else begin
            w_abs = w_q[pac_pkg::ANGLE_BITS-1:0];
        end
    end

    assign o_angle = r_neg ? $signed(-w_abs) : $signed(w_abs);

endmodule

/* design/pac_ctrl.sv */
// Sequencer that steps one item through the lane stages.
module pac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    output logic               o_in_ready,
    output logic               o_out_load,
    output pac_pkg::t_lane_ctl o_ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_LEVEL,
        ST_OFFSET,
        ST_SCALE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_first;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_load = (r_state == ST_DONE) && i_out_free;

    always_comb begin
        o_ctl        = '0;
        o_ctl.load   = o_in_ready && i_in_valid;
        o_ctl.mult   = (r_state == ST_SMOOTH);
        o_ctl.level  = (r_state == ST_LEVEL);
        o_ctl.offset = (r_state == ST_OFFSET);
        o_ctl.scale  = (r_state == ST_SCALE);
        o_ctl.divide = (r_state == ST_DIVIDE);
        o_ctl.first  = r_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_SMOOTH;
                    end
                end
                ST_SMOOTH: r_state <= ST_LEVEL;
                ST_LEVEL: begin
                    r_first <= 1'b0;
                    r_state <= ST_OFFSET;
                end
                ST_OFFSET: r_state <= ST_SCALE;
                ST_SCALE:  r_state <= ST_DIVIDE;
                ST_DIVIDE: r_state <= ST_DONE;
                ST_DONE: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* design/pac_merge.sv */
// Output register that gathers the lane angles into one result word.
module pac_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic signed [pac_pkg::ANGLE_BITS-1:0] i_angle [pac_pkg::CHANNELS],
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_out_free,
    output logic signed [pac_pkg::ANGLE_BITS-1:0] o_angle [pac_pkg::CHANNELS]
);

    logic r_valid;
    logic signed [pac_pkg::ANGLE_BITS-1:0] r_angle [pac_pkg::CHANNELS];

    assign o_out_free  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_angle     = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_angle <= i_angle;
        end
    end

endmodule

/* design/pot_angle_conditioner_core.sv */
// Top level: configuration registers, per-channel lanes, sequencer and output register.
// Each word passes the smooth, level, offset, scale, divide and done steps before the output register loads it.
// A new word is taken only in idle, so it waits for the six-step lane sequence
// and the return to idle; the output register lets the next word in while a result waits.
// Reset: synchronous, active low; clears smoothing levels, marks the next word as the
// first, and loads register defaults.
module pot_angle_conditioner_core #(
    parameter int FRACTION_BITS = pac_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0]  i_sample_pitch,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0]  i_sample_roll,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0]  i_sample_yaw,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [pac_pkg::ANGLE_BITS-1:0]   o_angle_pitch,
    output logic signed [pac_pkg::ANGLE_BITS-1:0]   o_angle_roll,
    output logic signed [pac_pkg::ANGLE_BITS-1:0]   o_angle_yaw,
    input  logic                                    i_cfg_we,
    input  logic        [pac_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic        [pac_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SB = pac_pkg::SAMPLE_BITS;
    localparam int CH = pac_pkg::CHANNELS;

    logic [SB-1:0]                    r_center [CH];
    logic [SB-1:0]                    r_dead_band;
    logic [pac_pkg::ALPHA_BITS-1:0]   r_alpha;
    logic [pac_pkg::LIMIT_BITS-1:0]   r_limit;

    logic [SB-1:0]                          w_sample [CH];
    logic signed [pac_pkg::ANGLE_BITS-1:0]  w_lane_angle [CH];
    logic signed [pac_pkg::ANGLE_BITS-1:0]  w_out_angle [CH];
    pac_pkg::t_lane_ctl                     w_ctl;
    logic                                   w_out_load;
    logic                                   w_out_free;

    assign w_sample[0] = i_sample_pitch;
    assign w_sample[1] = i_sample_roll;
    assign w_sample[2] = i_sample_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH; c++) begin
                r_center[c] <= pac_pkg::CENTER_RST;
            end
            r_dead_band <= pac_pkg::DEAD_RST;
            r_alpha     <= pac_pkg::ALPHA_RST;
            r_limit     <= pac_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            case (pac_pkg::t_reg_idx'(i_cfg_idx))
                pac_pkg::REG_CENTER_PITCH: r_center[0] <= i_cfg_data[SB-1:0];
                pac_pkg::REG_CENTER_ROLL:  r_center[1] <= i_cfg_data[SB-1:0];
                pac_pkg::REG_CENTER_YAW:   r_center[2] <= i_cfg_data[SB-1:0];
                pac_pkg::REG_DEAD_BAND:    r_dead_band <= i_cfg_data[SB-1:0];
                pac_pkg::REG_ALPHA:        r_alpha <= i_cfg_data[pac_pkg::ALPHA_BITS-1:0];
                pac_pkg::REG_ANGLE_LIMIT:  r_limit <= i_cfg_data[pac_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    pac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_out_load (w_out_load),
        .o_ctl      (w_ctl)
    );

    for (genvar g = 0; g < CH; g++) begin : g_lane
        pac_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (w_sample[g]),
            .i_center    (r_center[g]),
            .i_dead_band (r_dead_band),
            .i_alpha     (r_alpha),
            .i_limit     (r_limit),
            .o_angle     (w_lane_angle[g])
        );
    end

    pac_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_out_load),
        .i_angle     (w_lane_angle),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_free  (w_out_free),
        .o_angle     (w_out_angle)
    );

    assign o_angle_pitch = w_out_angle[0];
    assign o_angle_roll  = w_out_angle[1];
    assign o_angle_yaw   = w_out_angle[2];

endmodule

/* design/pac_checker.sv */
// Port-level checks for the pot angle conditioner, bound to the top level.
module pac_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [pac_pkg::ANGLE_BITS-1:0] i_angle_pitch
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready)
        else $error("input taken while a word is in progress");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result shown too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_angle_pitch))
        else $error("stalled output dropped or changed");

endmodule

bind pot_angle_conditioner_core pac_checker u_pac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_ready    (o_in_ready),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_angle_pitch (o_angle_pitch)
);

/* verif/pac_checker.sv */
// Checker for the pot angle conditioner: predicts each angle word and compares it.
`timescale 1ns / 1ps
module pac_tb_checker (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  logic                                     i_in_ready,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0]   i_sample_pitch,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0]   i_sample_roll,
    input  logic        [pac_pkg::SAMPLE_BITS-1:0]   i_sample_yaw,
    input  logic                                     i_out_valid,
    input  logic                                     i_out_ready,
    input  logic signed [pac_pkg::ANGLE_BITS-1:0]    i_angle_pitch,
    input  logic signed [pac_pkg::ANGLE_BITS-1:0]    i_angle_roll,
    input  logic signed [pac_pkg::ANGLE_BITS-1:0]    i_angle_yaw,
    input  logic                                     i_cfg_we,
    input  logic        [pac_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic        [pac_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                       o_mismatches,
    output int                                       o_pending
);

    localparam int SB          = pac_pkg::SAMPLE_BITS;
    localparam int AB          = pac_pkg::ALPHA_BITS;
    localparam int LB          = pac_pkg::LIMIT_BITS;
    localparam int GB          = pac_pkg::ANGLE_BITS;
    localparam int CH          = pac_pkg::CHANNELS;
    localparam int FRAC        = pac_pkg::FRACTION_BITS_DEF;
    localparam int LEVEL_BITS  = SB + FRAC;
    localparam int ALPHA_ONE   = 65536;
    localparam int MAX_REPORTS = 10;

    typedef logic [SB-1:0]         t_sample;
    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic signed [GB-1:0]  t_angle;

    typedef struct packed {
        t_angle pitch;
        t_angle roll;
        t_angle yaw;
    } t_angles;

    t_sample       center [CH];
    t_sample       dead_band;
    logic [AB-1:0] alpha;
    logic [LB-1:0] limit;
    t_level        level [CH];
    logic          first_pending;
    t_angles       angle_q [$];
    int            mismatches = 0;
    int            pending = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;

    function automatic t_level smooth(t_level lvl, t_sample smp);
        logic [63:0] acc;
        acc = 64'(alpha) * (64'(smp) << FRAC) + (64'(ALPHA_ONE) - 64'(alpha)) * 64'(lvl);
        return t_level'(acc >> AB);
    endfunction

    function automatic t_angle level_to_angle(t_level lvl, t_sample ctr);
        t_sample           whole;
        logic              neg;
        t_sample           mag;
        logic [SB+LB-1:0]  prod;
        logic [GB-1:0]     a;
        whole = lvl[LEVEL_BITS-1:FRAC];
        neg   = whole < ctr;
        mag   = neg ? ctr - whole : whole - ctr;
        if (mag < dead_band) begin
            return '0;
        end
        if (mag >= pac_pkg::HALF_SCALE) begin
            a = GB'(limit);
        end else begin
            prod = mag * limit;
            a    = GB'(prod / pac_pkg::HALF_SCALE);
        end
        return neg ? -a : a;
    endfunction

    task automatic write_reg(logic [pac_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [pac_pkg::CFG_DATA_BITS-1:0] data);
        case (pac_pkg::t_reg_idx'(idx))
            pac_pkg::REG_CENTER_PITCH: center[0] = data[SB-1:0];
            pac_pkg::REG_CENTER_ROLL:  center[1] = data[SB-1:0];
            pac_pkg::REG_CENTER_YAW:   center[2] = data[SB-1:0];
            pac_pkg::REG_DEAD_BAND:    dead_band = data[SB-1:0];
            pac_pkg::REG_ALPHA:        alpha     = data[AB-1:0];
            pac_pkg::REG_ANGLE_LIMIT:  limit     = data[LB-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_word(t_sample p, t_sample r, t_sample y);
        t_sample smp [CH];
        t_angle  ang [CH];
        smp[0] = p;
        smp[1] = r;
        smp[2] = y;
        for (int ch = 0; ch < CH; ch++) begin
            level[ch] = first_pending ? t_level'(smp[ch]) << FRAC : smooth(level[ch], smp[ch]);
            ang[ch]   = level_to_angle(level[ch], center[ch]);
        end
        first_pending = 1'b0;
        angle_q.push_back(t_angles'{ang[0], ang[1], ang[2]});
    endtask

    task automatic flag(string what, t_angle want, t_angle got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
        end
    endtask

    task automatic check_word();
        t_angles want;
        t_angles got;
        got = t_angles'{i_angle_pitch, i_angle_roll, i_angle_yaw};
        if (angle_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t ns: unexpected word %0d/%0d/%0d", $time,
                         got.pitch, got.roll, got.yaw);
            end
            return;
        end
        want = angle_q.pop_front();
        if (got.pitch !== want.pitch) flag("angle_pitch", want.pitch, got.pitch);
        if (got.roll !== want.roll)   flag("angle_roll", want.roll, got.roll);
        if (got.yaw !== want.yaw)     flag("angle_yaw", want.yaw, got.yaw);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CH; ch++) begin
                center[ch] = pac_pkg::CENTER_RST;
                level[ch]  = '0;
            end
            dead_band     = pac_pkg::DEAD_RST;
            alpha         = pac_pkg::ALPHA_RST;
            limit         = pac_pkg::LIMIT_RST;
            first_pending = 1'b1;
            angle_q.delete();
        end else begin
            if (i_cfg_we) begin
                write_reg(i_cfg_idx, i_cfg_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_word();
            end
            if (i_in_valid && i_in_ready) begin
                predict_word(i_sample_pitch, i_sample_roll, i_sample_yaw);
            end
        end
        pending = angle_q.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top: drives samples and register writes into the conditioner and reports the verdict.
`timescale 1ns / 1ps
module tb;

    localparam int SB           = pac_pkg::SAMPLE_BITS;
    localparam int AB           = pac_pkg::ALPHA_BITS;
    localparam int LB           = pac_pkg::LIMIT_BITS;
    localparam int CH           = pac_pkg::CHANNELS;
    localparam int CLK_PERIOD   = 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 225;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [pac_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [pac_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [SB-1:0] SAMPLE_MAX = '1;
    localparam logic [AB-1:0] ALPHA_MAX  = '1;
    localparam logic [LB-1:0] LIMIT_MAX  = '1;

    typedef logic [SB-1:0] t_sample;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     in_valid = 1'b0;
    logic                                     in_ready;
    t_sample                                  sample_pitch = '0;
    t_sample                                  sample_roll = '0;
    t_sample                                  sample_yaw = '0;
    logic                                     out_valid;
    logic                                     out_ready = 1'b0;
    logic signed [pac_pkg::ANGLE_BITS-1:0]    angle_pitch;
    logic signed [pac_pkg::ANGLE_BITS-1:0]    angle_roll;
    logic signed [pac_pkg::ANGLE_BITS-1:0]    angle_yaw;
    logic                                     cfg_we = 1'b0;
    logic        [pac_pkg::CFG_IDX_BITS-1:0]  cfg_idx = '0;
    logic        [pac_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    int      mismatches;
    int      pending;
    int      cycles = 0;
    int      src_idle = 0;
    int      sink_stall = 0;
    t_sample ctr [CH];
    t_sample prev [CH];

    pot_angle_conditioner_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_sample_pitch (sample_pitch),
        .i_sample_roll  (sample_roll),
        .i_sample_yaw   (sample_yaw),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_angle_pitch  (angle_pitch),
        .o_angle_roll   (angle_roll),
        .o_angle_yaw    (angle_yaw),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    pac_tb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_sample_pitch (sample_pitch),
        .i_sample_roll  (sample_roll),
        .i_sample_yaw   (sample_yaw),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_angle_pitch  (angle_pitch),
        .i_angle_roll   (angle_roll),
        .i_angle_yaw    (angle_yaw),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("** pot_angle_conditioner_core: FAILED **");
            $finish;
        end
    end

    task automatic send_word(t_sample p, t_sample r, t_sample y);
        while ($urandom_range(99) < src_idle) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid     = 1'b1;
        sample_pitch = p;
        sample_roll  = r;
        sample_yaw   = y;
        prev[0]      = p;
        prev[1]      = r;
        prev[2]      = y;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [pac_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [pac_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
    endtask

    // Pad unused upper data bits with noise; the block must mask them.
    task automatic set_config(t_sample c0, t_sample c1, t_sample c2, t_sample dead,
                              logic [AB-1:0] alpha, logic [LB-1:0] limit);
        write_reg(pac_pkg::REG_CENTER_PITCH, {4'($urandom), c0});
        write_reg(pac_pkg::REG_CENTER_ROLL, {4'($urandom), c1});
        write_reg(pac_pkg::REG_CENTER_YAW, {4'($urandom), c2});
        write_reg(pac_pkg::REG_DEAD_BAND, {4'($urandom), dead});
        write_reg(pac_pkg::REG_ALPHA, alpha);
        write_reg(pac_pkg::REG_ANGLE_LIMIT, {1'($urandom), limit});
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));
        cfg_we = 1'b0;
        ctr[0] = c0;
        ctr[1] = c1;
        ctr[2] = c2;
    endtask

    function automatic t_sample pick_center();
        int k;
        k = $urandom_range(9);
        if (k == 0) return '0;
        if (k == 1) return SAMPLE_MAX;
        return t_sample'($urandom);
    endfunction

    task automatic random_config();
        t_sample       dead;
        logic [AB-1:0] alpha;
        dead  = ($urandom_range(3) == 0) ? t_sample'($urandom) : t_sample'($urandom_range(64));
        case ($urandom_range(3))
            0:       alpha = AB'($urandom);
            1:       alpha = AB'($urandom_range(4000));
            default: alpha = AB'($urandom_range(30000, 65535));
        endcase
        set_config(pick_center(), pick_center(), pick_center(), dead, alpha,
                   LB'($urandom));
    endtask

    // Mostly runs around the center, the clamp edges and held values, with some noise.
    function automatic t_sample pick_sample(t_sample c, t_sample last);
        int k;
        k = $urandom_range(99);
        if (k < 25) return t_sample'(int'(c) + int'($urandom_range(80)) - 40);
        if (k < 35) return $urandom_range(1) ? SAMPLE_MAX : t_sample'(0);
        if (k < 45) begin
            return t_sample'(int'(c) + ($urandom_range(1) ? 2047 : -2047)
                             + int'($urandom_range(2)) - 1);
        end
        if (k < 65) return last;
        return t_sample'($urandom);
    endfunction

    task automatic set_pace(int phase);
        case (phase % 4)
            0: begin src_idle = 0;  sink_stall = 0;  end
            1: begin src_idle = 57; sink_stall = 0;  end
            2: begin src_idle = 0;  sink_stall = 57; end
            default: begin src_idle = 26; sink_stall = 26; end
        endcase
    endtask

    initial begin
        for (int ch = 0; ch < CH; ch++) begin
            ctr[ch]  = pac_pkg::CENTER_RST;
            prev[ch] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: first word loads the levels directly
        send_word(SAMPLE_MAX, 12'd0, 12'd2048);
        send_word(12'd0, SAMPLE_MAX, 12'd2048);
        send_word(12'd2048, 12'd2048, 12'd2048);
        drain();

        // near-full tracking, dead band and clamp edges
        set_config(12'd2048, 12'd2048, 12'd2048, 12'd20, ALPHA_MAX, LIMIT_MAX);
        send_word(12'd2068, 12'd2028, 12'd2067);
        send_word(12'd2068, 12'd2028, 12'd2067);
        send_word(12'd2067, 12'd2029, SAMPLE_MAX);
        send_word(12'd2067, 12'd2029, SAMPLE_MAX);
        send_word(12'd1, 12'd2, 12'd4094);
        send_word(12'd1, 12'd2, 12'd4094);
        send_word(12'd0, SAMPLE_MAX, 12'd2048);
        drain();

        // frozen levels, no dead band
        set_config(12'd0, SAMPLE_MAX, 12'd2048, 12'd0, 16'd0, LIMIT_MAX);
        send_word(12'd0, SAMPLE_MAX, 12'd1234);
        send_word(SAMPLE_MAX, 12'd0, 12'd3000);
        send_word(t_sample'($urandom), t_sample'($urandom), t_sample'($urandom));
        drain();

        // widest dead band, zero limit
        set_config(12'd2048, 12'd0, SAMPLE_MAX, SAMPLE_MAX, 16'd1, '0);
        send_word(12'd0, SAMPLE_MAX, 12'd0);
        send_word(SAMPLE_MAX, 12'd0, SAMPLE_MAX);
        send_word(12'd2048, 12'd2048, 12'd2048);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            set_pace(phase);
            case (phase)
                0: set_config(pac_pkg::CENTER_RST, pac_pkg::CENTER_RST, pac_pkg::CENTER_RST,
                              pac_pkg::DEAD_RST, pac_pkg::ALPHA_RST, pac_pkg::LIMIT_RST);
                1: set_config(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, ALPHA_MAX,
                              LIMIT_MAX);
                2: set_config(12'd0, 12'd0, 12'd0, 12'd0, ALPHA_MAX, LIMIT_MAX);
                default: random_config();
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(pick_sample(ctr[0], prev[0]), pick_sample(ctr[1], prev[1]),
                          pick_sample(ctr[2], prev[2]));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** pot_angle_conditioner_core: PASSED **");
        end else begin
            $display("** pot_angle_conditioner_core: FAILED **");
        end
        $finish;
    end

endmodule
